### hdl/blr_pkg.sv
// Package for the line rasterizer: coordinate widths, beat structs and codes.
// No dependencies; used by bresenham_line_rasterizer_top.
`default_nettype none

package blr_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 4;
  localparam int CLIP_BITS  = 11;
  // Signed endpoint difference.
  localparam int DIFF_BITS  = COORD_BITS + 1;
  // Error term and increments reach +/- 2 * (2^COORD_BITS - 1).
  localparam int ERR_BITS   = COORD_BITS + 3;
  // Common width for the signed clip compares.
  localparam int CMP_BITS   = ((COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS) + 1;

  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_ENABLE = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_SIZE   = CFG_INDEX_BITS'(1);

  localparam logic [CLIP_BITS-1:0] CLIP_SIZE_RESET = CLIP_BITS'(512);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic [COLOR_BITS-1:0]        color_t;

  typedef struct packed {
    logic   command;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t pen_color;
  } in_item_t;

  typedef struct packed {
    logic   valid_res;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   visible;
    logic   last;
  } out_item_t;

endpackage

`default_nettype wire

### hdl/bresenham_line_rasterizer_top.sv
// Integer line rasterizer, top level: line setup, per-pixel step, result register.
// Depends on blr_pkg.
// Every input beat gives exactly one result beat, one item per clock unless
// stalled: a start beat sets up the line and returns its first pixel, each step
// beat returns the next pixel (last set on the final one), and a step with no
// line active returns a beat with valid_res low. The result register is loaded
// directly from the input beat; the longest path is line setup (two endpoint
// subtracts, absolute values, major-axis compare, error-term add). The input
// stalls only while a held result is stalled at the output. Visibility against
// the clip window is decoded from the result register and the clip registers.
`default_nettype none

module bresenham_line_rasterizer_top import blr_pkg::*; (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire                       out_stall,
  output out_item_t                 out_data,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire [CLIP_BITS-1:0]       cfg_data
);

  // Configuration
  logic                 clip_enable_r;
  logic [CLIP_BITS-1:0] clip_size_r;

  // Line state
  logic   busy_r, busy_nxt;
  logic   steep_r, steep_nxt;
  coord_t major_pos_r, major_pos_nxt;
  coord_t minor_pos_r, minor_pos_nxt;
  coord_t major_stop_r, major_stop_nxt;
  logic   minor_neg_r, minor_neg_nxt;
  err_t   error_r, error_nxt;
  err_t   diag_incr_r, diag_incr_nxt;
  err_t   axial_incr_r, axial_incr_nxt;
  color_t line_color_r, line_color_nxt;

  // Result register (visible is decoded at the port)
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  logic in_accept;

  // Setup terms
  diff_t                 dx, dy, dmaj_s, dmin_s;
  logic [COORD_BITS-1:0] adx, ady, dmaj, dmin;
  logic                  s_steep, s_swap;
  coord_t                maj_a, maj_b, min_a, min_b;

  // Step terms
  coord_t step_major;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_enable_r <= 1'b0;
      clip_size_r   <= CLIP_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLIP_ENABLE: clip_enable_r <= cfg_data[0];
        REG_CLIP_SIZE:   clip_size_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dx  = DIFF_BITS'(in_data.x_end) - DIFF_BITS'(in_data.x_start);
    dy  = DIFF_BITS'(in_data.y_end) - DIFF_BITS'(in_data.y_start);
    adx = dx[DIFF_BITS-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ady = dy[DIFF_BITS-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    s_steep = adx < ady;
    dmaj    = s_steep ? ady : adx;
    dmin    = s_steep ? adx : ady;
    dmaj_s  = s_steep ? dy : dx;
    dmin_s  = s_steep ? dx : dy;
    maj_a   = s_steep ? in_data.y_start : in_data.x_start;
    maj_b   = s_steep ? in_data.y_end   : in_data.x_end;
    min_a   = s_steep ? in_data.x_start : in_data.y_start;
    min_b   = s_steep ? in_data.x_end   : in_data.y_end;
    // endpoints ordered so the major coordinate rises
    s_swap  = dmaj_s[DIFF_BITS-1];

    step_major = major_pos_r + COORD_BITS'(1);

    busy_nxt       = busy_r;
    steep_nxt      = steep_r;
    major_pos_nxt  = major_pos_r;
    minor_pos_nxt  = minor_pos_r;
    major_stop_nxt = major_stop_r;
    minor_neg_nxt  = minor_neg_r;
    error_nxt      = error_r;
    diag_incr_nxt  = diag_incr_r;
    axial_incr_nxt = axial_incr_r;
    line_color_nxt = line_color_r;

    if (in_data.command == CMD_START) begin
      steep_nxt      = s_steep;
      major_pos_nxt  = s_swap ? maj_b : maj_a;
      minor_pos_nxt  = s_swap ? min_b : min_a;
      major_stop_nxt = s_swap ? maj_a : maj_b;
      // minor moves down unless the ordered minor end is strictly above
      minor_neg_nxt  = s_swap ? ~dmin_s[DIFF_BITS-1]
                             : (dmin_s[DIFF_BITS-1] || dmin_s == '0);
      error_nxt      = $signed(ERR_BITS'({dmin, 1'b0})) - $signed(ERR_BITS'(dmaj));
      diag_incr_nxt  = $signed(ERR_BITS'({dmin, 1'b0})) - $signed(ERR_BITS'({dmaj, 1'b0}));
      axial_incr_nxt = $signed(ERR_BITS'({dmin, 1'b0}));
      line_color_nxt = in_data.pen_color;
      busy_nxt       = dmaj != '0;
    end else if (busy_r) begin
      major_pos_nxt = step_major;
      if (!error_r[ERR_BITS-1]) begin
        minor_pos_nxt = minor_neg_r ? minor_pos_r - COORD_BITS'(1)
                                    : minor_pos_r + COORD_BITS'(1);
        error_nxt     = error_r + diag_incr_r;
      end else begin
        error_nxt     = error_r + axial_incr_r;
      end
      busy_nxt = step_major != major_stop_r;
    end

    out_item_nxt = '0;
    if (in_data.command == CMD_START || busy_r) begin
      out_item_nxt.valid_res   = 1'b1;
      out_item_nxt.pixel_x     = steep_nxt ? minor_pos_nxt : major_pos_nxt;
      out_item_nxt.pixel_y     = steep_nxt ? major_pos_nxt : minor_pos_nxt;
      out_item_nxt.pixel_color = line_color_nxt;
      out_item_nxt.last        = ~busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      steep_r      <= 1'b0;
      major_pos_r  <= '0;
      minor_pos_r  <= '0;
      major_stop_r <= '0;
      minor_neg_r  <= 1'b0;
      error_r      <= '0;
      diag_incr_r  <= '0;
      axial_incr_r <= '0;
      line_color_r <= '0;
    end else if (in_accept) begin
      busy_r       <= busy_nxt;
      steep_r      <= steep_nxt;
      major_pos_r  <= major_pos_nxt;
      minor_pos_r  <= minor_pos_nxt;
      major_stop_r <= major_stop_nxt;
      minor_neg_r  <= minor_neg_nxt;
      error_r      <= error_nxt;
      diag_incr_r  <= diag_incr_nxt;
      axial_incr_r <= axial_incr_nxt;
      line_color_r <= line_color_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Clip window: 0 < x,y < clip_size, strict. The user must change the clip
  // registers only while no result is pending (held beat stable); not enforced.
  logic signed [CMP_BITS-1:0] px_c, py_c, lim_c;
  logic                       in_window;

  always_comb begin
    px_c      = CMP_BITS'(out_item_r.pixel_x);
    py_c      = CMP_BITS'(out_item_r.pixel_y);
    lim_c     = $signed(CMP_BITS'(clip_size_r));
    in_window = (px_c > 0) && (py_c > 0) && (px_c < lim_c) && (py_c < lim_c);

    out_data         = out_item_r;
    out_data.visible = out_item_r.valid_res & (~clip_enable_r | in_window);
  end

  assign out_valid = out_valid_r;

  // A step with no line active returns an empty beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.command == CMD_STEP && !busy_r) |=> !out_item_r.valid_res)
    else $error("idle step produced a pixel");

  // After any beat, the line stays active exactly when the pixel was not the last.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (busy_r == (out_item_r.valid_res && !out_item_r.last)))
    else $error("busy state disagrees with last flag");

  // A start always returns a pixel.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.command == CMD_START) |=> (out_valid_r && out_item_r.valid_res))
    else $error("start beat lost its pixel");

endmodule

`default_nettype wire
